[rtl/s2dascii_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII converter.
// Depends on nothing; imported by the converter's top level.
package s2dascii_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int IN_DATA_W           = 32;
    localparam int CHAR_W              = 8;
    localparam int POS_W               = 4;
    localparam int OUT_DATA_W          = 16;
    localparam int DIGIT_W             = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter: bit-serial
// double dabble followed by one character per transfer. Depends on s2dascii_pkg.
//
//  Channel  Direction  Signals                     Contents
//  s_*      in         s_tvalid s_tready s_tdata   value to convert (32 bits, signed)
//  m_*      out        m_tvalid m_tready m_tdata   character [7:0], position [11:8]
//                      m_tlast                     set on the final character
//
// An accepted value is loaded, passes through the double-dabble loop (one
// magnitude bit shifted into the BCD register per cycle), and is then emitted
// one character at a time, the minus sign first for a negative value.
// The next value is taken once the final character has entered the output
// register, while that character may still be waiting to be taken.
// A stall on m_tready holds the output register and pauses character emission.
// The asynchronous reset clears the sequencer and the output valid flag;
// the BCD digits and the magnitude hold no reset value.
module signed_int_to_decimal_ascii
    import s2dascii_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] character, [11:8] position, rest zero
    output logic                  m_tlast
);

    // Decimal digits needed for any magnitude below 2**VALUE_WIDTH
    // (1233/4096 approximates log10 of two closely enough for this range).
    localparam int NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int BIT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       ndig_reg, ndig_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [POS_W-1:0]       pos_reg, pos_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic                   out_last_reg, out_last_next;

    logic [VALUE_WIDTH-1:0] value_ext;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_shift;
    logic [NDIG-1:0]        digit_nz;
    logic                   slot_free;
    logic                   in_accept;
    logic [DIGIT_W-1:0]     cur_digit;

    // Only the low VALUE_WIDTH bits of the input take part; a wider converter
    // sees the 32-bit input zero-extended.
    generate
        if (VALUE_WIDTH <= IN_DATA_W)
        begin : g_trunc
            assign value_ext = s_tdata[VALUE_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign value_ext = {{(VALUE_WIDTH - IN_DATA_W){1'b0}}, s_tdata};
        end
    endgenerate

    // Add three to every BCD digit of five or more, then shift the next
    // magnitude bit in at the bottom.
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
        bcd_shift = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
        for (int d = 0; d < NDIG; d++)
        begin
            digit_nz[d] = (bcd_shift[d*DIGIT_W +: DIGIT_W] != '0);
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign cur_digit = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bcd_next       = bcd_reg;
        ndig_next      = ndig_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next  = value_ext[VALUE_WIDTH-1];
                    mag_next  = value_ext[VALUE_WIDTH-1] ? (~value_ext + 1'b1) : value_ext;
                    bcd_next  = '0;
                    ndig_next = CNT_W'(1);
                    bit_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next = bcd_shift;
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                // The leading digit can move up by at most one place per step.
                if ((ndig_reg < CNT_W'(NDIG)) && digit_nz[ndig_reg[IDX_W-1:0]])
                begin
                    ndig_next = ndig_reg + 1'b1;
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BIT_W'(VALUE_WIDTH - 1))
                begin
                    pos_next   = '0;
                    idx_next   = IDX_W'(ndig_next - 1'b1);
                    state_next = neg_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_pos_next   = pos_reg;
                    out_last_next  = 1'b0;
                    pos_next       = pos_reg + 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, cur_digit};
                    out_pos_next   = pos_reg;
                    out_last_next  = (idx_reg == '0);
                    pos_next       = pos_reg + 1'b1;
                    idx_next       = idx_reg - 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ndig_reg      <= CNT_W'(1);
            bit_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            bit_reg       <= bit_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - CHAR_W - POS_W){1'b0}}, out_pos_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

    // A minus sign only ever opens the text.
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[CHAR_W-1:0] == CHAR_MINUS)) |-> (m_tdata[11:8] == '0))
        else $error("minus sign away from position zero");

    // The digit count stays within the BCD register.
    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ndig_reg >= CNT_W'(1)) && (ndig_reg <= CNT_W'(NDIG)))
        else $error("digit count out of range");

    // An accepted value always starts a conversion.
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_CONV))
        else $error("accepted transfer did not start conversion");

    // A result held under a stall is not replaced.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule
